FILE: rtl/core/ipv4ff_pkg.sv
// Package for the IPv4 receive frame filter with fragment sequencing.
// Holds verdict codes, register indexes and frame layout constants.
// No dependencies.
`default_nettype none

package ipv4ff_pkg;

    typedef enum logic [2:0] {
        V_RX_ERROR   = 3'd0,
        V_ARP        = 3'd1,
        V_FIRST_FRAG = 3'd2,
        V_NEXT_FRAG  = 3'd3,
        V_NO_CHAIN   = 3'd4,
        V_WRONG_SEQ  = 3'd5,
        V_INVALID    = 3'd6
    } t_verdict;

    typedef enum logic [1:0] {
        REG_OWN_MAC      = 2'd0,
        REG_OWN_IP       = 2'd1,
        REG_MIN_LENGTH   = 2'd2,
        REG_FRAG_STEP    = 2'd3
    } t_reg_index;

    localparam int CFG_DATA_W  = 48;
    localparam int OUT_LEN_W   = 11;
    localparam int OFFSET_W    = 13;

    localparam logic [10:0]         MIN_LENGTH_RST = 11'd34;
    localparam logic [12:0]         FRAG_STEP_RST  = 13'd185;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_MAX   = 11'h7FF;

    localparam logic [7:0]  VERSION_IHL   = 8'h45;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_ARP     = 16'h0806;
    localparam logic [15:0] SUM_OK        = 16'hFFFF;
    localparam logic [7:0]  OFF_HIGH_MASK = 8'h1F;

    // byte positions within the frame
    localparam int POS_MAC_END   = 6;
    localparam int POS_ETYPE_HI  = 12;
    localparam int POS_ETYPE_LO  = 13;
    localparam int POS_VERSION   = 14;
    localparam int POS_OFF_HI    = 20;
    localparam int POS_OFF_LO    = 21;
    localparam int POS_PROTO     = 23;
    localparam int POS_IP_FIRST  = 30;
    localparam int POS_IP_LAST   = 33;
    localparam int POS_SUM_FIRST = 14;

endpackage

`default_nettype wire

FILE: rtl/core/ipv4_frame_filter_fragment_tracker_unit.sv
// Top level of the IPv4 receive frame filter with fragment sequencing.
// Depends on ipv4ff_pkg.
//
// Takes one frame byte per cycle and gives one verdict per frame, registered
// and shown the cycle after the last byte is transferred. Header fields are
// checked on the fly as bytes pass, so a byte is taken every cycle with no
// gaps between frames; the only hold-off is a full result register that the
// receiver stalls. The per-byte path is one 16-bit end-around checksum add
// and the verdict compare. Configuration writes are taken every cycle.
`default_nettype none

module ipv4_frame_filter_fragment_tracker_unit #(
    parameter int LENGTH_BITS = 11
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // frame byte channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [7:0]                          i_data_byte,
    input  wire logic                                i_last_byte,
    input  wire logic                                i_rx_error,
    // verdict channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [2:0]                               o_verdict,
    output logic [ipv4ff_pkg::OUT_LEN_W-1:0]         o_frame_length,
    output logic [ipv4ff_pkg::OFFSET_W-1:0]          o_fragment_offset,
    // configuration write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [1:0]                          i_cfg_index,
    input  wire logic [ipv4ff_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ipv4ff_pkg::*;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic [47:0]          r_own_mac;
    logic [31:0]          r_own_ip;
    logic [10:0]          r_min_length;
    logic [OFFSET_W-1:0]  r_frag_step;

    // per-frame state
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic                   r_mac_match, n_mac_match;
    logic [15:0]            r_ether_type, n_ether_type;
    logic                   r_version_ok, n_version_ok;
    logic                   r_protocol_ok, n_protocol_ok;
    logic                   r_ip_match, n_ip_match;
    logic [15:0]            r_sum, n_sum;
    logic [7:0]             r_hold, n_hold;
    logic [OFFSET_W-1:0]    r_offset, n_offset;

    // fragment chain
    logic                   r_chain_active, n_chain_active;
    logic [OFFSET_W-1:0]    r_last_offset, n_last_offset;

    // result register
    logic                   r_out_valid;
    t_verdict               r_out_verdict, n_verdict;
    logic [OUT_LEN_W-1:0]   r_out_length, n_out_length;
    logic [OFFSET_W-1:0]    r_out_offset, n_out_offset;

    logic                   in_xfer;
    logic [7:0]             mac_want;
    logic [7:0]             ip_want;
    logic [16:0]            sum_wide;
    logic [OFFSET_W:0]      seq_expect;
    logic                   ipv4_ok;

    assign o_stall     = r_out_valid && i_stall;
    assign in_xfer     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign o_valid           = r_out_valid;
    assign o_verdict         = r_out_verdict;
    assign o_frame_length    = r_out_length;
    assign o_fragment_offset = r_out_offset;

    always_comb begin
        unique case (r_count[2:0])
            3'd0:    mac_want = r_own_mac[47:40];
            3'd1:    mac_want = r_own_mac[39:32];
            3'd2:    mac_want = r_own_mac[31:24];
            3'd3:    mac_want = r_own_mac[23:16];
            3'd4:    mac_want = r_own_mac[15:8];
            3'd5:    mac_want = r_own_mac[7:0];
            default: mac_want = 8'h00;
        endcase
        // positions 30..33 map by their low two bits
        unique case (r_count[1:0])
            2'b10:   ip_want = r_own_ip[31:24];
            2'b11:   ip_want = r_own_ip[23:16];
            2'b00:   ip_want = r_own_ip[15:8];
            default: ip_want = r_own_ip[7:0];
        endcase
    end

    // field capture for the byte being transferred
    always_comb begin
        n_mac_match   = r_mac_match;
        n_ether_type  = r_ether_type;
        n_version_ok  = r_version_ok;
        n_protocol_ok = r_protocol_ok;
        n_ip_match    = r_ip_match;
        n_sum         = r_sum;
        n_hold        = r_hold;
        n_offset      = r_offset;
        sum_wide      = {1'b0, r_sum} + {1'b0, r_hold, i_data_byte};

        if (r_count < LENGTH_BITS'(POS_MAC_END)) begin
            if (i_data_byte != mac_want) begin
                n_mac_match = 1'b0;
            end
        end
        if (r_count == LENGTH_BITS'(POS_ETYPE_HI)) begin
            n_ether_type = {i_data_byte, 8'h00};
        end
        if (r_count == LENGTH_BITS'(POS_ETYPE_LO)) begin
            n_ether_type = {r_ether_type[15:8], i_data_byte};
        end
        if (r_count == LENGTH_BITS'(POS_VERSION)) begin
            n_version_ok = (i_data_byte == VERSION_IHL);
        end
        if (r_count == LENGTH_BITS'(POS_OFF_HI)) begin
            n_offset = {i_data_byte[4:0] & OFF_HIGH_MASK[4:0], 8'h00};
        end
        if (r_count == LENGTH_BITS'(POS_OFF_LO)) begin
            n_offset = {r_offset[12:8], i_data_byte};
        end
        if (r_count == LENGTH_BITS'(POS_PROTO)) begin
            n_protocol_ok = (i_data_byte == PROTO_UDP);
        end
        if (r_count >= LENGTH_BITS'(POS_IP_FIRST) && r_count <= LENGTH_BITS'(POS_IP_LAST)) begin
            if (i_data_byte != ip_want) begin
                n_ip_match = 1'b0;
            end
        end
        if (r_count >= LENGTH_BITS'(POS_SUM_FIRST) && r_count <= LENGTH_BITS'(POS_IP_LAST)) begin
            if (!r_count[0]) begin
                n_hold = i_data_byte;
            end else begin
                // ones' complement: fold the carry back in
                n_sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end

        n_count = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;
    end

    // verdict for a last byte
    always_comb begin
        n_chain_active = r_chain_active;
        n_last_offset  = r_last_offset;
        n_out_offset   = '0;
        seq_expect     = {1'b0, r_last_offset} + {1'b0, r_frag_step};
        ipv4_ok        = (n_ether_type == ETYPE_IPV4) && n_mac_match && n_ip_match &&
                         n_version_ok && n_protocol_ok && (n_sum == SUM_OK);

        if (n_count > LENGTH_BITS'(OUT_LEN_MAX)) begin
            n_out_length = OUT_LEN_MAX;
        end else begin
            n_out_length = OUT_LEN_W'(n_count);
        end

        priority if (i_rx_error || (n_count < LENGTH_BITS'(r_min_length))) begin
            n_verdict = V_RX_ERROR;
        end else if (n_ether_type == ETYPE_ARP) begin
            n_verdict = V_ARP;
        end else if (ipv4_ok) begin
            n_out_offset = n_offset;
            priority if (n_offset == '0) begin
                n_verdict      = V_FIRST_FRAG;
                n_chain_active = 1'b1;
                n_last_offset  = '0;
            end else if (!r_chain_active) begin
                n_verdict = V_NO_CHAIN;
            end else if (seq_expect != {1'b0, n_offset}) begin
                n_verdict = V_WRONG_SEQ;
            end else begin
                n_verdict     = V_NEXT_FRAG;
                n_last_offset = n_offset;
            end
        end else begin
            n_verdict = V_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac    <= '0;
            r_own_ip     <= '0;
            r_min_length <= MIN_LENGTH_RST;
            r_frag_step  <= FRAG_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_OWN_MAC:    r_own_mac    <= i_cfg_data[47:0];
                REG_OWN_IP:     r_own_ip     <= i_cfg_data[31:0];
                REG_MIN_LENGTH: r_min_length <= i_cfg_data[10:0];
                REG_FRAG_STEP:  r_frag_step  <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_mac_match    <= 1'b1;
            r_ether_type   <= '0;
            r_version_ok   <= 1'b0;
            r_protocol_ok  <= 1'b0;
            r_ip_match     <= 1'b1;
            r_sum          <= '0;
            r_hold         <= '0;
            r_offset       <= '0;
            r_chain_active <= 1'b0;
            r_last_offset  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_xfer && i_last_byte) begin
                r_count        <= '0;
                r_mac_match    <= 1'b1;
                r_ether_type   <= '0;
                r_version_ok   <= 1'b0;
                r_protocol_ok  <= 1'b0;
                r_ip_match     <= 1'b1;
                r_sum          <= '0;
                r_hold         <= '0;
                r_offset       <= '0;
                r_chain_active <= n_chain_active;
                r_last_offset  <= n_last_offset;
                r_out_valid    <= 1'b1;
            end else begin
                if (in_xfer) begin
                    r_count       <= n_count;
                    r_mac_match   <= n_mac_match;
                    r_ether_type  <= n_ether_type;
                    r_version_ok  <= n_version_ok;
                    r_protocol_ok <= n_protocol_ok;
                    r_ip_match    <= n_ip_match;
                    r_sum         <= n_sum;
                    r_hold        <= n_hold;
                    r_offset      <= n_offset;
                end
                if (!i_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_last_byte) begin
            r_out_verdict <= n_verdict;
            r_out_length  <= n_out_length;
            r_out_offset  <= n_out_offset;
        end
    end

    // assertions
    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_last_byte) |=> (r_count == '0))
        else $error("byte counter not cleared after frame end");

    a_first_sets_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_verdict == V_FIRST_FRAG) |-> r_chain_active)
        else $error("first fragment without active chain");

    a_next_updates_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_last_byte && n_verdict == V_NEXT_FRAG)
            |=> (r_last_offset == r_out_offset))
        else $error("chain offset not tracked on next fragment");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_verdict == V_RX_ERROR || r_out_verdict == V_ARP ||
                         r_out_verdict == V_INVALID || r_out_verdict == V_FIRST_FRAG))
            |-> (r_out_offset == '0))
        else $error("nonzero offset on a verdict that carries none");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the IPv4 receive frame filter with fragment sequencing.
// Streams frame bytes, predicts each verdict on the fly and checks every verdict transfer.
// Depends on ipv4ff_pkg and ipv4_frame_filter_fragment_tracker_unit.
`timescale 1ns / 1ps

module testbench;
    import ipv4ff_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_PCT      = 16;
    localparam int HDR_BYTES     = 34;
    localparam int EXT_MIN_LEN   = 64;
    localparam int PHASE_BYTES   = 200;
    localparam int PHASE_FRAMES  = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_rx_item;

    typedef struct packed {
        t_verdict              verdict;
        logic [OUT_LEN_W-1:0]  length;
        logic [OFFSET_W-1:0]   offset;
    } t_frame_verdict;

    typedef enum int {FLAW_MAC, FLAW_IP, FLAW_VERSION, FLAW_PROTO, FLAW_ETYPE, FLAW_SUM} t_flaw;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [7:0]             i_data_byte = '0;
    logic                   i_last_byte = 1'b0;
    logic                   i_rx_error = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [2:0]             o_verdict;
    logic [OUT_LEN_W-1:0]   o_frame_length;
    logic [OFFSET_W-1:0]    o_fragment_offset;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    ipv4_frame_filter_fragment_tracker_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_rx_error        (i_rx_error),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_verdict         (o_verdict),
        .o_frame_length    (o_frame_length),
        .o_fragment_offset (o_fragment_offset),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // register copies, updated on each config transfer
    logic [47:0]          cfg_mac = '0;
    logic [31:0]          cfg_ip = '0;
    logic [10:0]          cfg_min_len = MIN_LENGTH_RST;
    logic [12:0]          cfg_step = FRAG_STEP_RST;

    // per-frame parse state and fragment chain
    logic [OUT_LEN_W-1:0] fp_count = '0;
    bit                   fp_mac_ok = 1'b1;
    logic [15:0]          fp_etype = '0;
    bit                   fp_ver_ok = 1'b0;
    bit                   fp_proto_ok = 1'b0;
    bit                   fp_ip_ok = 1'b1;
    logic [15:0]          fp_sum = '0;
    logic [7:0]           fp_hold = '0;
    logic [12:0]          fp_off = '0;
    bit                   chain_open = 1'b0;
    logic [12:0]          chain_last = '0;

    t_rx_item             wire_bytes[$];
    t_frame_verdict       expected_verdicts[$];
    logic [7:0]           frame_buf[$];

    int  in_flight = 0;
    int  bytes_taken = 0;
    int  mismatches = 0;
    int  quiet = 0;
    int  verdict_tally[7];
    bit  calm = 1'b0;

    // stimulus-side chain tracking
    bit          chain_begun = 1'b0;
    logic [13:0] seq_next = '0;

    // Parse one accepted byte; on the last byte, push the verdict it yields.
    function void classify_byte(logic [7:0] b, logic last, logic err);
        int             pos;
        logic [16:0]    acc;
        t_frame_verdict r;
        pos = fp_count;
        if (pos < POS_MAC_END) begin
            if (b != cfg_mac[8*(5-pos) +: 8]) fp_mac_ok = 1'b0;
        end else if (pos == POS_ETYPE_HI) begin
            fp_etype = {b, 8'h00};
        end else if (pos == POS_ETYPE_LO) begin
            fp_etype[7:0] = b;
        end
        if (pos == POS_VERSION) fp_ver_ok = (b == VERSION_IHL);
        if (pos == POS_OFF_HI) fp_off = {b[4:0], 8'h00};
        if (pos == POS_OFF_LO) fp_off[7:0] = b;
        if (pos == POS_PROTO) fp_proto_ok = (b == PROTO_UDP);
        if (pos >= POS_IP_FIRST && pos <= POS_IP_LAST) begin
            if (b != cfg_ip[8*(POS_IP_LAST-pos) +: 8]) fp_ip_ok = 1'b0;
        end
        if (pos >= POS_SUM_FIRST && pos <= POS_IP_LAST) begin
            if (pos % 2 == 0) begin
                fp_hold = b;
            end else begin
                acc = fp_sum + {fp_hold, b};
                fp_sum = acc[15:0] + acc[16];
            end
        end
        if (fp_count != OUT_LEN_MAX) fp_count++;
        if (!last) return;

        r.length = fp_count;
        r.offset = '0;
        if (err || fp_count < cfg_min_len) begin
            r.verdict = V_RX_ERROR;
        end else if (fp_etype == ETYPE_ARP) begin
            r.verdict = V_ARP;
        end else if (fp_etype == ETYPE_IPV4 && fp_mac_ok && fp_ip_ok && fp_ver_ok &&
                     fp_proto_ok && fp_sum == SUM_OK) begin
            r.offset = fp_off;
            if (fp_off == '0) begin
                r.verdict = V_FIRST_FRAG;
                chain_open = 1'b1;
                chain_last = '0;
            end else if (!chain_open) begin
                r.verdict = V_NO_CHAIN;
            end else if ({1'b0, chain_last} + {1'b0, cfg_step} != {1'b0, fp_off}) begin
                // no wrap: a sum past 13 bits never matches
                r.verdict = V_WRONG_SEQ;
            end else begin
                r.verdict = V_NEXT_FRAG;
                chain_last = fp_off;
            end
        end else begin
            r.verdict = V_INVALID;
        end
        expected_verdicts.push_back(r);

        fp_count = '0;
        fp_mac_ok = 1'b1;
        fp_etype = '0;
        fp_ver_ok = 1'b0;
        fp_proto_ok = 1'b0;
        fp_ip_ok = 1'b1;
        fp_sum = '0;
        fp_hold = '0;
        fp_off = '0;
    endfunction

    // byte driver
    always @(posedge i_clk) begin : drive_bytes
        t_rx_item nxt;
        if (i_valid && !o_stall) begin
            classify_byte(i_data_byte, i_last_byte, i_rx_error);
            bytes_taken++;
            in_flight--;
        end
        if (!i_valid || !o_stall) begin
            if (wire_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = wire_bytes.pop_front();
                i_valid <= 1'b1;
                i_data_byte <= nxt.data;
                i_last_byte <= nxt.last;
                i_rx_error <= nxt.err;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // verdict monitor
    always @(posedge i_clk) begin : check_verdicts
        t_frame_verdict got;
        t_frame_verdict want;
        if (o_valid && !i_stall) begin
            got.verdict = t_verdict'(o_verdict);
            got.length = o_frame_length;
            got.offset = o_fragment_offset;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: verdict %0d len %0d off %0d with none expected",
                             $realtime, o_verdict, o_frame_length, o_fragment_offset);
            end else begin
                want = expected_verdicts.pop_front();
                verdict_tally[want.verdict]++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: expected verdict %0d len %0d off %0d, ",
                                  "got %0d len %0d off %0d"},
                                 $realtime, want.verdict, want.length, want.offset,
                                 o_verdict, o_frame_length, o_fragment_offset);
                end
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // no-progress watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function void seal_checksum();
        logic [16:0] acc;
        acc = '0;
        frame_buf[24] = 8'h00;
        frame_buf[25] = 8'h00;
        for (int k = POS_SUM_FIRST; k <= POS_IP_LAST; k += 2) begin
            acc = acc[15:0] + {frame_buf[k], frame_buf[k+1]};
            acc = acc[15:0] + acc[16];
        end
        frame_buf[24] = ~acc[15:8];
        frame_buf[25] = ~acc[7:0];
    endfunction

    // well-formed Ethernet II + IPv4/UDP header, then pad bytes of payload
    function void build_udp_frame(logic [47:0] dmac, logic [31:0] dip, logic [12:0] off, int pad);
        frame_buf.delete();
        for (int k = 0; k < 6; k++) frame_buf.push_back(dmac[8*(5-k) +: 8]);
        repeat (6) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(ETYPE_IPV4[15:8]);
        frame_buf.push_back(ETYPE_IPV4[7:0]);
        frame_buf.push_back(VERSION_IHL);
        repeat (5) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back({3'($urandom_range(0, 7)), off[12:8]});
        frame_buf.push_back(off[7:0]);
        frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(PROTO_UDP);
        repeat (6) frame_buf.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < 4; k++) frame_buf.push_back(dip[8*(3-k) +: 8]);
        repeat (pad) frame_buf.push_back(8'($urandom_range(0, 255)));
        seal_checksum();
    endfunction

    function void make_arp();
        frame_buf[POS_ETYPE_HI] = ETYPE_ARP[15:8];
        frame_buf[POS_ETYPE_LO] = ETYPE_ARP[7:0];
    endfunction

    // one-bit flip in a single checked field; the checksum is resealed unless it is the target
    function void corrupt_frame(t_flaw flaw);
        int         spot;
        logic [7:0] flip;
        flip = 8'(1) << $urandom_range(0, 7);
        case (flaw)
            FLAW_MAC:     spot = $urandom_range(0, POS_MAC_END - 1);
            FLAW_IP:      spot = $urandom_range(POS_IP_FIRST, POS_IP_LAST);
            FLAW_VERSION: spot = POS_VERSION;
            FLAW_PROTO:   spot = POS_PROTO;
            FLAW_ETYPE:   spot = POS_ETYPE_HI + $urandom_range(0, 1);
            default:      spot = 24;
        endcase
        frame_buf[spot] = frame_buf[spot] ^ flip;
        if (flaw != FLAW_SUM) seal_checksum();
    endfunction

    function void truncate_frame(int keep);
        while (frame_buf.size() > keep) void'(frame_buf.pop_back());
    endfunction

    function int queue_frame(bit bad_end, int early_pct);
        t_rx_item item;
        for (int k = 0; k < frame_buf.size(); k++) begin
            item.data = frame_buf[k];
            item.last = (k == frame_buf.size() - 1);
            item.err = item.last ? bad_end : ($urandom_range(0, 99) < early_pct);
            wire_bytes.push_back(item);
            in_flight++;
        end
        return frame_buf.size();
    endfunction

    function logic [12:0] chain_offset();
        logic [12:0] off;
        if (!chain_begun || seq_next > 14'd8191) begin
            off = '0;
            seq_next = {1'b0, cfg_step};
            chain_begun = 1'b1;
        end else begin
            off = seq_next[12:0];
            seq_next = seq_next + cfg_step;
        end
        return off;
    endfunction

    // mostly in-sequence fragments, the rest broken or foreign frames
    function int queue_random_frame();
        int          pick;
        int          pad;
        logic [12:0] off;
        pick = $urandom_range(0, 99);
        pad = ((cfg_min_len > HDR_BYTES) ? int'(cfg_min_len) - HDR_BYTES : 0)
              + $urandom_range(0, 10);
        if (pick < 62) begin
            build_udp_frame(cfg_mac, cfg_ip, chain_offset(), pad);
        end else if (pick < 70) begin
            off = seq_next[12:0] + 13'($urandom_range(1, 50));
            build_udp_frame(cfg_mac, cfg_ip, off, pad);
        end else if (pick < 76) begin
            build_udp_frame(cfg_mac, cfg_ip, 13'($urandom_range(0, 8191)), pad);
            make_arp();
        end else if (pick < 88) begin
            build_udp_frame(cfg_mac, cfg_ip, chain_offset(), pad);
            corrupt_frame(t_flaw'($urandom_range(0, 5)));
        end else if (pick < 94) begin
            build_udp_frame(cfg_mac, cfg_ip, 13'($urandom_range(0, 8191)), pad);
            return queue_frame(1'b1, 12);
        end else if (pick < 97) begin
            build_udp_frame(cfg_mac, cfg_ip, chain_offset(), pad);
            truncate_frame($urandom_range(1, HDR_BYTES - 1));
        end else begin
            frame_buf.delete();
            repeat ($urandom_range(HDR_BYTES, 60)) frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        return queue_frame(1'b0, 12);
    endfunction

    task automatic wait_drained();
        @(posedge i_clk);
        while (in_flight != 0 || expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // writes all four registers back to back; upper data bits carry junk to exercise masking
    task automatic write_config(logic [47:0] mac, logic [31:0] ip, logic [10:0] min_len,
                                logic [12:0] step);
        logic [47:0] vals[4];
        vals[REG_OWN_MAC]    = mac;
        vals[REG_OWN_IP]     = {16'($urandom), ip};
        vals[REG_MIN_LENGTH] = {37'({$urandom, $urandom}), min_len};
        vals[REG_FRAG_STEP]  = {35'({$urandom, $urandom}), step};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_reg_index'(k);
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            case (t_reg_index'(k))
                REG_OWN_MAC:    cfg_mac = vals[k];
                REG_OWN_IP:     cfg_ip = vals[k][31:0];
                REG_MIN_LENGTH: cfg_min_len = vals[k][10:0];
                REG_FRAG_STEP:  cfg_step = vals[k][12:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
        chain_begun = 1'b0;
    endtask

    initial begin : stimulus
        int sent;
        int frames;
        int total_frames;
        int short_cuts[7];
        short_cuts = '{1, 6, 13, 14, 21, 24, 33};
        total_frames = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values: address 0, minimum 34, step 185
        build_udp_frame(cfg_mac, cfg_ip, 13'd185, 0);   // no chain yet
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd0, 0);     // chain start, exactly minimum length
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd185, 5);   // in sequence, error flag on every early byte
        void'(queue_frame(1'b0, 100));
        build_udp_frame(cfg_mac, cfg_ip, 13'd999, 3);   // out of sequence
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd370, 0);
        make_arp();
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd370, 0);   // receive error flag on last byte
        void'(queue_frame(1'b1, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd370, 0);   // one byte short of minimum
        truncate_frame(HDR_BYTES - 1);
        void'(queue_frame(1'b0, 0));
        for (int k = FLAW_MAC; k <= FLAW_SUM; k++) begin
            build_udp_frame(cfg_mac, cfg_ip, 13'd370, 2);
            corrupt_frame(t_flaw'(k));
            void'(queue_frame(1'b0, 0));
        end
        build_udp_frame(cfg_mac, cfg_ip, 13'd370, 30);   // payload only adds to the length
        void'(queue_frame(1'b0, 0));
        frame_buf.delete();
        repeat (40) frame_buf.push_back(8'($urandom_range(0, 255)));
        void'(queue_frame(1'b0, 0));
        wait_drained();

        // upper extremes: all-ones addresses, maximum step
        write_config('1, '1, 11'(EXT_MIN_LEN), 13'h1FFF);
        build_udp_frame(cfg_mac, cfg_ip, 13'd0, EXT_MIN_LEN - HDR_BYTES);
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'h1FFF, EXT_MIN_LEN - HDR_BYTES);
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'h1FFF, EXT_MIN_LEN - HDR_BYTES);   // sum runs past 13 bits
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'h1FFF, EXT_MIN_LEN - 1 - HDR_BYTES);
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd0, 6);
        void'(queue_frame(1'b0, 0));
        wait_drained();

        // minimum below the header size: short frames judged on what was seen
        write_config({$urandom, $urandom}, $urandom, 11'd0, 13'd1);
        foreach (short_cuts[k]) begin
            build_udp_frame(cfg_mac, cfg_ip, 13'd0, 0);
            truncate_frame(short_cuts[k]);
            void'(queue_frame(1'b0, 0));
        end
        build_udp_frame(cfg_mac, cfg_ip, 13'd5, 0);
        make_arp();
        truncate_frame(POS_ETYPE_LO + 1);
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd0, 0);
        void'(queue_frame(1'b0, 0));
        build_udp_frame(cfg_mac, cfg_ip, 13'd1, 0);
        void'(queue_frame(1'b0, 0));
        wait_drained();

        // random traffic over several settings; one stretch with no idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_config({$urandom, $urandom}, $urandom, 11'($urandom_range(34, 60)),
                                13'($urandom_range(1, 400)));
                1: write_config({$urandom, $urandom}, $urandom, 11'($urandom_range(34, 60)),
                                13'd0);
                2: write_config({$urandom, $urandom}, $urandom, 11'($urandom_range(34, 60)),
                                13'($urandom_range(1, 8191)));
                default: write_config({$urandom, $urandom}, $urandom,
                                      11'($urandom_range(0, 33)), 13'($urandom_range(1, 40)));
            endcase
            calm = (ph == 2);
            sent = 0;
            frames = 0;
            while (sent < PHASE_BYTES || frames < PHASE_FRAMES) begin
                sent += queue_random_frame();
                frames++;
            end
            total_frames += frames;
            wait_drained();
            calm = 1'b0;
        end

        $display("%0d bytes transferred, %0d random frames; verdicts error %0d, arp %0d, first %0d,",
                 bytes_taken, total_frames, verdict_tally[V_RX_ERROR], verdict_tally[V_ARP],
                 verdict_tally[V_FIRST_FRAG]);
        $display("next %0d, no-chain %0d, wrong-seq %0d, invalid %0d; mismatches %0d",
                 verdict_tally[V_NEXT_FRAG], verdict_tally[V_NO_CHAIN],
                 verdict_tally[V_WRONG_SEQ], verdict_tally[V_INVALID], mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
